// ----- hdl/flh64_pkg.sv -----
// ============================================================================
// flh64_pkg - shared types and constants of the four-lane hash engine
// Item classes passed from the front end to the lane datapath, the queue
// entry, the multiplier request and response, and the hash constants.
// ============================================================================
package flh64_pkg;

    // Default width of the stored message length
    localparam int LENGTH_BITS_DEF = 32;

    // Fixed field widths
    localparam int WORD_W = 64;
    localparam int LEN_W  = 32;
    localparam int IDX_W  = 30;

    // Entries in the queue between front end and datapath
    localparam int QUEUE_DEPTH = 4;

    // Mixing constants
    localparam logic [WORD_W-1:0] K_P  = 64'h9E37_79B9_7F4A_7C15;
    localparam logic [WORD_W-1:0] K_M1 = 64'h85EB_CA77_C2B2_AE3D;
    localparam logic [WORD_W-1:0] K_M2 = 64'hBF58_476D_1CE4_E5B9;
    localparam logic [WORD_W-1:0] K_M3 = 64'h94D0_49BB_1331_11EB;

    // What the datapath does with one word
    typedef enum logic [1:0] {
        OP_NONE,
        OP_STORE,
        OP_STRIPE,
        OP_FOLD
    } t_op;

    // One classified item
    typedef struct packed {
        logic              start;
        logic              last;
        t_op               op;
        logic [1:0]        slot;
        logic [WORD_W-1:0] word;
        logic [WORD_W-1:0] seed;
        logic [LEN_W-1:0]  len;
    } t_item;

    // Datapath sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LP,
        ST_I0,
        ST_I1,
        ST_I2,
        ST_I3,
        ST_EXEC,
        ST_F0,
        ST_F1,
        ST_F2,
        ST_F3,
        ST_EMIT
    } t_bstate;

    // Multiplier request and response
    typedef struct packed {
        logic              start;
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
    } t_mul_req;

    typedef struct packed {
        logic              busy;
        logic              done;
        logic [WORD_W-1:0] p;
    } t_mul_rsp;

endpackage

// ----- hdl/four_lane_hash64_engine_unit.sv -----
// ============================================================================
// four_lane_hash64_engine_unit - four-lane multiply-rotate 64-bit hash
// Streams little-endian message words, seeds four lanes from seed and
// length, mixes whole stripes, folds the remainder and emits the digest.
// ============================================================================
//  channel   direction  handshake         payload
//  input     in         push / full       i_data_word, i_seed, i_total_length
//  result    out        empty / pop       o_digest
//  config    in         i_cfg_wr_en       i_cfg_wr_data (round mode)
//
//  The front end takes one word a cycle, while the queue is not full, into a
//  four-entry item queue. The datapath carries out a middle word in the cycle
//  that it reads it; the first word waits for the seeding products and the
//  last for the finaliser products, all on the one shared 32x32 multiplier.
//  Reset is synchronous, active low, and drops any message in progress.
//  An unpopped digest stalls the datapath when the next digest is ready.
// ============================================================================
module four_lane_hash64_engine_unit
    import flh64_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic [WORD_W-1:0] i_data_word,
    input  logic [WORD_W-1:0] i_seed,
    input  logic [LEN_W-1:0]  i_total_length,
    output logic              empty,
    input  logic              pop,
    output logic [WORD_W-1:0] o_digest,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data
);

    logic     q_wr;
    t_item    q_wr_item;
    logic     q_rd;
    logic     q_empty;
    t_item    q_rd_item;
    t_mul_req mul_req;
    t_mul_rsp mul_rsp;

    flh64_front #(
        .LENGTH_BITS (LENGTH_BITS)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_data_word    (i_data_word),
        .i_seed         (i_seed),
        .i_total_length (i_total_length),
        .i_q_full       (full),
        .o_q_wr         (q_wr),
        .o_q_item       (q_wr_item)
    );

    flh64_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_item  (q_wr_item),
        .o_full  (full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_item  (q_rd_item)
    );

    flh64_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (mul_req),
        .o_rsp   (mul_rsp)
    );

    flh64_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_q_empty     (q_empty),
        .i_q_item      (q_rd_item),
        .o_q_rd        (q_rd),
        .o_mul_req     (mul_req),
        .i_mul_rsp     (mul_rsp),
        .o_empty       (empty),
        .i_pop         (pop),
        .o_digest      (o_digest)
    );

endmodule

// ----- hdl/flh64_front.sv -----
// ============================================================================
// flh64_front - message tracker and item classifier
// Tracks the word position within the current message, latches the length
// on the first item and tags every word as stripe store, stripe update,
// lane-1 fold or nothing, with the tail bytes already masked.
// ============================================================================
module flh64_front
    import flh64_pkg::*;
#(
    parameter int LENGTH_BITS = LENGTH_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [WORD_W-1:0] i_data_word,
    input  logic [WORD_W-1:0] i_seed,
    input  logic [LEN_W-1:0]  i_total_length,
    input  logic              i_q_full,
    output logic              o_q_wr,
    output t_item             o_q_item
);

    localparam int LW = (LENGTH_BITS < LEN_W) ? LENGTH_BITS : LEN_W;
    localparam int CW = IDX_W + 1;
    localparam logic [1:0] STRIPE_LAST = 2'd3;

    logic             r_in_msg, n_in_msg;
    logic [IDX_W-1:0] r_widx, n_widx;
    logic [LW-1:0]    r_len, n_len;

    logic [LW-1:0]     cur_len;
    logic [IDX_W-1:0]  idx;
    logic [CW-1:0]     full_w;
    logic [CW-1:0]     stripe_w;
    logic [CW-1:0]     items;
    logic [CW-1:0]     idx_x;
    logic [CW-1:0]     idx_nx;
    logic [2:0]        rem;
    logic [WORD_W-1:0] tail_mask;
    logic              accept;

    assign accept = i_push && !i_q_full;
    assign o_q_wr = accept;

    // Classify the word on the input
    always_comb begin
        cur_len  = r_in_msg ? r_len : i_total_length[LW-1:0];
        idx      = r_in_msg ? r_widx : '0;
        full_w   = CW'(cur_len >> 3);
        stripe_w = CW'((cur_len >> 5) << 2);
        rem      = cur_len[2:0];
        items    = (cur_len == '0) ? CW'(1) : (full_w + CW'(rem != 3'd0));
        idx_x    = CW'(idx);
        idx_nx   = idx_x + CW'(1);

        for (int b = 0; b < 8; b++) begin
            tail_mask[8*b +: 8] = (3'(b) < rem) ? 8'hFF : 8'h00;
        end

        o_q_item.start = !r_in_msg;
        o_q_item.last  = (idx_nx >= items);
        o_q_item.slot  = idx[1:0];
        o_q_item.word  = i_data_word;
        o_q_item.seed  = i_seed;
        o_q_item.len   = LEN_W'(cur_len);

        if (idx_x < stripe_w) begin
            o_q_item.op = (idx[1:0] == STRIPE_LAST) ? OP_STRIPE : OP_STORE;
        end else if (idx_x < full_w) begin
            o_q_item.op = OP_FOLD;
        end else if (rem != 3'd0) begin
            o_q_item.op   = OP_FOLD;
            o_q_item.word = i_data_word & tail_mask;
        end else begin
            o_q_item.op = OP_NONE;
        end
    end

    // Advance the word position, drop back to idle after the last word
    always_comb begin
        n_in_msg = r_in_msg;
        n_widx   = r_widx;
        n_len    = r_len;
        if (accept) begin
            n_len = cur_len;
            if (o_q_item.last) begin
                n_in_msg = 1'b0;
                n_widx   = '0;
            end else begin
                n_in_msg = 1'b1;
                n_widx   = idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_msg <= 1'b0;
            r_widx   <= '0;
        end else begin
            r_in_msg <= n_in_msg;
            r_widx   <= n_widx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_len <= n_len;
    end

endmodule

// ----- hdl/flh64_fifo.sv -----
// ============================================================================
// flh64_fifo - item queue between front end and datapath
// Small first-in first-out store of classified items; lets the front end
// keep taking words while the datapath is busy with products.
// ============================================================================
module flh64_fifo
    import flh64_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_wr,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_rd,
    output logic  o_empty,
    output t_item o_item
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QUEUE_DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(QUEUE_DEPTH);

    t_item         r_mem [QUEUE_DEPTH];
    logic [PW-1:0] r_wp, n_wp;
    logic [PW-1:0] r_rp, n_rp;
    logic [NW-1:0] r_cnt, n_cnt;
    logic          wr_ok;
    logic          rd_ok;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_empty = (r_cnt == '0);
    assign o_item  = r_mem[r_rp];
    assign wr_ok   = i_wr && !o_full;
    assign rd_ok   = i_rd && !o_empty;

    // Advance the pointers and the fill count
    always_comb begin
        n_wp  = r_wp;
        n_rp  = r_rp;
        n_cnt = r_cnt;
        if (wr_ok) begin
            n_wp = (r_wp == LAST_PTR) ? '0 : r_wp + PW'(1);
        end
        if (rd_ok) begin
            n_rp = (r_rp == LAST_PTR) ? '0 : r_rp + PW'(1);
        end
        if (wr_ok && !rd_ok) begin
            n_cnt = r_cnt + NW'(1);
        end else if (rd_ok && !wr_ok) begin
            n_cnt = r_cnt - NW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
        end
    end

    // Store the incoming item
    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[r_wp] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL_CNT)
        else $error("queue fill count beyond depth");

    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0 || r_cnt == FULL_CNT) |-> (r_wp == r_rp))
        else $error("queue pointers disagree with fill count");

    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !i_rd) |=> o_full)
        else $error("full queue lost an item without a read");
`endif

endmodule

// ----- hdl/flh64_mul.sv -----
// ============================================================================
// flh64_mul - iterative 64x64 multiplier, low half of the product
// Builds the low 64 bits from three 32x32 partial products on one shared
// multiplier, one partial product a cycle, registered before summing.
// ============================================================================
module flh64_mul
    import flh64_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mul_req i_req,
    output t_mul_rsp o_rsp
);

    localparam int HW = WORD_W / 2;
    localparam logic [1:0] STEP_LL  = 2'd0;
    localparam logic [1:0] STEP_LH  = 2'd1;
    localparam logic [1:0] STEP_HL  = 2'd2;

    logic [WORD_W-1:0] r_a, r_b;
    logic [WORD_W-1:0] r_prod;
    logic [WORD_W-1:0] r_acc;
    logic [1:0]        r_step;
    logic              r_busy;
    logic              r_done;

    logic [HW-1:0]     op_a, op_b;
    logic [WORD_W-1:0] mul_out;

    // Select the partial product for this step
    always_comb begin
        case (r_step)
            STEP_LL: begin
                op_a = r_a[HW-1:0];
                op_b = r_b[HW-1:0];
            end
            STEP_LH: begin
                op_a = r_a[HW-1:0];
                op_b = r_b[WORD_W-1:HW];
            end
            default: begin
                op_a = r_a[WORD_W-1:HW];
                op_b = r_b[HW-1:0];
            end
        endcase
    end

    // Zero-extend the halves so the full 64-bit product is kept
    assign mul_out = WORD_W'(op_a) * WORD_W'(op_b);

    // Step through the partial products and accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= STEP_LL;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_step <= STEP_LL;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_step <= r_step + 2'd1;
                case (r_step)
                    STEP_LL: begin
                        r_prod <= mul_out;
                    end
                    STEP_LH: begin
                        r_acc  <= r_prod;
                        r_prod <= mul_out;
                    end
                    STEP_HL: begin
                        r_acc  <= r_acc + {r_prod[HW-1:0], {HW{1'b0}}};
                        r_prod <= mul_out;
                    end
                    default: begin
                        r_acc  <= r_acc + {r_prod[HW-1:0], {HW{1'b0}}};
                        r_busy <= 1'b0;
                        r_done <= 1'b1;
                    end
                endcase
            end
        end
    end

    assign o_rsp.busy = r_busy;
    assign o_rsp.done = r_done;
    assign o_rsp.p    = r_acc;

endmodule

// ----- hdl/flh64_back.sv -----
// ============================================================================
// flh64_back - lane datapath and finaliser
// Takes classified items from the queue, seeds the lanes on the first word,
// applies stripe updates and lane-1 folds, finalises on the last word and
// holds the digest in an output register until it is taken.
// ============================================================================
module flh64_back
    import flh64_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_q_empty,
    input  t_item             i_q_item,
    output logic              o_q_rd,
    output t_mul_req          o_mul_req,
    input  t_mul_rsp          i_mul_rsp,
    output logic              o_empty,
    input  logic              i_pop,
    output logic [WORD_W-1:0] o_digest
);

    localparam int ROT_A = 11;
    localparam int ROT_B = 17;
    localparam int ROT_C = 23;
    localparam int ROT_D = 57;
    localparam int MIX_A = 31;
    localparam int MIX_B = 37;
    localparam int MIX_C = 43;
    localparam int MIX_D = 53;
    localparam int FIN_0 = 29;
    localparam int FIN_1 = 31;
    localparam int FIN_2 = 37;
    localparam int FIN_3 = 41;

    function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] v, input int n);
        return (v << n) | (v >> (WORD_W - n));
    endfunction

    t_bstate           r_state, n_state;
    logic              r_mode;
    logic              r_out_valid, n_out_valid;
    t_item             r_ent, n_ent;
    logic [WORD_W-1:0] r_lane [4];
    logic [WORD_W-1:0] n_lane [4];
    logic [WORD_W-1:0] r_buf [3];
    logic [WORD_W-1:0] n_buf [3];
    logic [WORD_W-1:0] r_base, n_base;
    logic [WORD_W-1:0] r_hold, n_hold;
    logic [WORD_W-1:0] r_digest;

    t_item             ex_item;
    logic              ex_do;
    logic              out_load;
    logic [WORD_W-1:0] sa, sb, sc, sd0, sd1;
    logic [WORD_W-1:0] ma, mb, mc, md;
    logic [WORD_W-1:0] fa;
    logic [WORD_W-1:0] lx;
    logic [WORD_W-1:0] mp;

    // Lane update candidates for the item being carried out
    always_comb begin
        ex_item = (r_state == ST_EXEC) ? r_ent : i_q_item;
        ex_do   = (r_state == ST_EXEC)
                || (r_state == ST_IDLE && !i_q_empty && !i_q_item.start);

        sa  = rotl((r_lane[0] ^ r_buf[0]) + r_lane[1], ROT_A);
        sb  = rotl((r_lane[1] ^ r_buf[1]) + r_lane[2], ROT_B);
        sc  = rotl((r_lane[2] ^ r_buf[2]) + r_lane[3], ROT_C);
        sd0 = rotl((r_lane[3] ^ ex_item.word) + sa, ROT_D);
        sd1 = rotl((r_lane[3] ^ ex_item.word) + r_lane[0], ROT_D);

        ma = sa ^ rotl(sd1, MIX_A);
        mb = sb ^ rotl(ma, MIX_B);
        mc = sc ^ rotl(mb, MIX_C);
        md = sd1 ^ rotl(mc, MIX_D);

        fa = rotl((r_lane[0] ^ ex_item.word) + r_lane[1], ROT_A);
        lx = r_lane[0] ^ r_lane[1] ^ r_lane[2] ^ r_lane[3];
        mp = i_mul_rsp.p;
    end

    // Sequence seeding, lane updates and finalisation
    always_comb begin
        n_state  = r_state;
        n_ent    = r_ent;
        n_lane   = r_lane;
        n_buf    = r_buf;
        n_base   = r_base;
        n_hold   = r_hold;
        o_q_rd   = 1'b0;
        o_mul_req = '0;
        out_load = 1'b0;

        // Carry out the word on the lanes
        if (ex_do) begin
            case (ex_item.op)
                OP_STORE: begin
                    for (int k = 0; k < 3; k++) begin
                        if (ex_item.slot == 2'(k)) begin
                            n_buf[k] = ex_item.word;
                        end
                    end
                end
                OP_STRIPE: begin
                    if (r_mode) begin
                        n_lane[0] = ma;
                        n_lane[1] = mb;
                        n_lane[2] = mc;
                        n_lane[3] = md;
                    end else begin
                        n_lane[0] = sa;
                        n_lane[1] = sb;
                        n_lane[2] = sc;
                        n_lane[3] = sd0;
                    end
                end
                OP_FOLD: begin
                    n_lane[0] = fa;
                end
                default: begin
                end
            endcase
        end

        case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_rd = 1'b1;
                    if (i_q_item.start) begin
                        n_ent           = i_q_item;
                        o_mul_req.start = 1'b1;
                        o_mul_req.a     = WORD_W'(i_q_item.len);
                        o_mul_req.b     = K_P;
                        n_state         = ST_LP;
                    end else if (i_q_item.last) begin
                        n_state = ST_F0;
                    end
                end
            end
            ST_LP: begin
                if (i_mul_rsp.done) begin
                    n_base          = r_ent.seed ^ mp;
                    o_mul_req.start = 1'b1;
                    o_mul_req.a     = r_ent.seed ^ mp;
                    o_mul_req.b     = K_P;
                    n_state         = ST_I0;
                end
            end
            ST_I0: begin
                if (i_mul_rsp.done) begin
                    n_lane[0]       = mp;
                    o_mul_req.start = 1'b1;
                    o_mul_req.a     = r_base;
                    o_mul_req.b     = K_M1;
                    n_state         = ST_I1;
                end
            end
            ST_I1: begin
                if (i_mul_rsp.done) begin
                    n_lane[1]       = mp;
                    o_mul_req.start = 1'b1;
                    o_mul_req.a     = r_base;
                    o_mul_req.b     = K_M2;
                    n_state         = ST_I2;
                end
            end
            ST_I2: begin
                if (i_mul_rsp.done) begin
                    n_lane[2]       = mp;
                    o_mul_req.start = 1'b1;
                    o_mul_req.a     = r_base;
                    o_mul_req.b     = K_M3;
                    n_state         = ST_I3;
                end
            end
            ST_I3: begin
                if (i_mul_rsp.done) begin
                    n_lane[3] = mp;
                    n_state   = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_state = r_ent.last ? ST_F0 : ST_IDLE;
            end
            ST_F0: begin
                o_mul_req.start = 1'b1;
                o_mul_req.a     = lx ^ (lx >> FIN_0);
                o_mul_req.b     = K_M1;
                n_state         = ST_F1;
            end
            ST_F1: begin
                if (i_mul_rsp.done) begin
                    o_mul_req.start = 1'b1;
                    o_mul_req.a     = mp ^ (mp >> FIN_1);
                    o_mul_req.b     = K_M2;
                    n_state         = ST_F2;
                end
            end
            ST_F2: begin
                if (i_mul_rsp.done) begin
                    o_mul_req.start = 1'b1;
                    o_mul_req.a     = mp ^ (mp >> FIN_2);
                    o_mul_req.b     = K_P;
                    n_state         = ST_F3;
                end
            end
            ST_F3: begin
                if (i_mul_rsp.done) begin
                    n_hold  = mp;
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (!r_out_valid) begin
                    out_load = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase

        // Hold the digest until it is taken
        if (out_load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_pop) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_mode      <= 1'b1;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            if (i_cfg_wr_en) begin
                r_mode <= i_cfg_wr_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent  <= n_ent;
        r_lane <= n_lane;
        r_buf  <= n_buf;
        r_base <= n_base;
        r_hold <= n_hold;
        if (out_load) begin
            r_digest <= r_hold ^ (r_hold >> FIN_3);
        end
    end

    assign o_empty  = !r_out_valid;
    assign o_digest = r_digest;

`ifndef SYNTHESIS
    a_done_waited: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_mul_rsp.done |-> (r_state == ST_LP || r_state == ST_I0 || r_state == ST_I1
            || r_state == ST_I2 || r_state == ST_I3 || r_state == ST_F1
            || r_state == ST_F2 || r_state == ST_F3))
        else $error("product arrived with nobody waiting");

    a_mul_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mul_req.start |-> !i_mul_rsp.busy)
        else $error("multiplier started while busy");

    a_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !r_out_valid) |=> (r_out_valid && r_state == ST_IDLE))
        else $error("digest not delivered to output register");
`endif

endmodule

// ----- tb/tb_four_lane_hash64_engine_unit.sv -----
`timescale 1ns / 100ps
// ============================================================================
// tb_four_lane_hash64_engine_unit - self-checking bench for the lane hash
// Streams messages of varied length through the push/full side, predicts
// each digest with a behavioural copy of the lane hash held in a scoreboard,
// and compares every popped digest in order. Both round modes are used,
// both sides idle at random, and the receiver holds off once for long
// enough that the engine fills and stalls its input.
// ============================================================================
module tb_four_lane_hash64_engine_unit;
    import flh64_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 5;
    localparam int SETTLE_CYCLES  = 40;
    localparam int HOLD_OFF_LEN   = 400;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_COUNT    = 6;
    localparam int PHASE_WORDS    = 125;

    // Word content of a message
    localparam int FILL_RANDOM = 0;
    localparam int FILL_ONES   = 1;
    localparam int FILL_ZERO   = 2;

    // Round mode codes
    localparam logic MODE_CHAINED = 1'b0;
    localparam logic MODE_CROSS   = 1'b1;

    // ------------------------------------------------------------------------
    // Digest predictor and in-order store of expected digests
    // ------------------------------------------------------------------------
    class digest_scoreboard;
        logic              round_mode;
        logic [WORD_W-1:0] lane [4];
        logic [WORD_W-1:0] stripe_word [3];
        logic [63:0]       word_count;
        logic [63:0]       msg_len;
        bit                in_msg;
        logic [WORD_W-1:0] expected_digests [$];
        int unsigned       mismatch_count;

        function new();
            int k;
            for (k = 0; k < 4; k++) lane[k] = '0;
            for (k = 0; k < 3; k++) stripe_word[k] = '0;
            word_count     = '0;
            msg_len        = '0;
            in_msg         = 1'b0;
            round_mode     = MODE_CROSS;
            mismatch_count = 0;
        endfunction

        function logic [WORD_W-1:0] rotl(logic [WORD_W-1:0] v, int n);
            return (v << n) | (v >> (64 - n));
        endfunction

        function void fold_lane(logic [WORD_W-1:0] w);
            lane[0] = rotl((lane[0] ^ w) + lane[1], 11);
        endfunction

        function void run_stripe(logic [WORD_W-1:0] last_word);
            logic [WORD_W-1:0] a, b, c, d;
            a = lane[0];
            b = lane[1];
            c = lane[2];
            d = lane[3];
            if (round_mode == MODE_CHAINED) begin
                // lane 4 takes the fresh lane 1
                a = rotl((a ^ stripe_word[0]) + b, 11);
                b = rotl((b ^ stripe_word[1]) + c, 17);
                c = rotl((c ^ stripe_word[2]) + d, 23);
                d = rotl((d ^ last_word) + a, 57);
                lane[0] = a;
                lane[1] = b;
                lane[2] = c;
                lane[3] = d;
            end else begin
                // update from the old lanes, then cross-mix
                lane[0] = rotl((a ^ stripe_word[0]) + b, 11);
                lane[1] = rotl((b ^ stripe_word[1]) + c, 17);
                lane[2] = rotl((c ^ stripe_word[2]) + d, 23);
                lane[3] = rotl((d ^ last_word) + a, 57);
                lane[0] = lane[0] ^ rotl(lane[3], 31);
                lane[1] = lane[1] ^ rotl(lane[0], 37);
                lane[2] = lane[2] ^ rotl(lane[1], 43);
                lane[3] = lane[3] ^ rotl(lane[2], 53);
            end
        endfunction

        function logic [WORD_W-1:0] final_mix();
            logic [WORD_W-1:0] h;
            h = lane[0] ^ lane[1] ^ lane[2] ^ lane[3];
            h = h ^ (h >> 29);
            h = h * K_M1;
            h = h ^ (h >> 31);
            h = h * K_M2;
            h = h ^ (h >> 37);
            h = h * K_P;
            h = h ^ (h >> 41);
            return h;
        endfunction

        // Advance the predictor by one accepted item
        function void note_word(logic [WORD_W-1:0] word, logic [WORD_W-1:0] seed,
                                logic [LEN_W-1:0] len);
            logic [WORD_W-1:0] base;
            logic [63:0]       n_full, n_stripe, n_items;
            int unsigned       tail;
            if (!in_msg) begin
                msg_len    = {32'd0, len};
                base       = seed ^ (msg_len * K_P);
                lane[0]    = base * K_P;
                lane[1]    = base * K_M1;
                lane[2]    = base * K_M2;
                lane[3]    = base * K_M3;
                word_count = '0;
                in_msg     = 1'b1;
            end
            n_full   = msg_len >> 3;
            n_stripe = (msg_len >> 5) << 2;
            n_items  = (msg_len == 0) ? 64'd1 : ((msg_len + 64'd7) >> 3);
            if (word_count < n_stripe) begin
                if (word_count[1:0] != 2'd3) stripe_word[word_count[1:0]] = word;
                else run_stripe(word);
            end else if (word_count < n_full) begin
                fold_lane(word);
            end else begin
                // keep only the low tail bytes
                tail = 32'(msg_len[2:0]);
                if (tail != 0) fold_lane(word & ((64'd1 << (8 * tail)) - 64'd1));
            end
            if (word_count + 64'd1 >= n_items) begin
                expected_digests.push_back(final_mix());
                in_msg     = 1'b0;
                word_count = '0;
            end else begin
                word_count = word_count + 64'd1;
            end
        endfunction

        function void check_digest(logic [WORD_W-1:0] got);
            logic [WORD_W-1:0] want;
            if (expected_digests.size() == 0) begin
                $display("%0t: unexpected digest, expected none, actual %h", $time, got);
                mismatch_count++;
            end else begin
                want = expected_digests.pop_front();
                if (got !== want) begin
                    $display("%0t: digest mismatch, expected %h, actual %h",
                             $time, want, got);
                    mismatch_count++;
                end
            end
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Signals and block instance
    // ------------------------------------------------------------------------
    logic              i_clk;
    logic              i_rst_n        = 1'b0;
    logic              push           = 1'b0;
    logic              full;
    logic [WORD_W-1:0] i_data_word    = '0;
    logic [WORD_W-1:0] i_seed         = '0;
    logic [LEN_W-1:0]  i_total_length = '0;
    logic              empty;
    logic              pop            = 1'b0;
    logic [WORD_W-1:0] o_digest;
    logic              i_cfg_wr_en    = 1'b0;
    logic              i_cfg_wr_data  = 1'b0;

    digest_scoreboard sb;
    bit               idling_on    = 1'b1;
    bit               hold_off_req = 1'b0;
    int               words_sent   = 0;
    int               quiet_cycles = 0;

    four_lane_hash64_engine_unit #(
        .LENGTH_BITS(LENGTH_BITS_DEF)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_data_word   (i_data_word),
        .i_seed        (i_seed),
        .i_total_length(i_total_length),
        .empty         (empty),
        .pop           (pop),
        .o_digest      (o_digest),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #CLK_HALF i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [63:0] pick_word(int fill);
        int r;
        if (fill == FILL_ONES) return '1;
        if (fill == FILL_ZERO) return '0;
        r = $urandom_range(0, 15);
        if (r == 0) return '1;
        if (r == 1) return '0;
        return rand64();
    endfunction

    // Mostly short messages, some stripe-heavy, a few near stripe boundaries
    function automatic logic [LEN_W-1:0] pick_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return $urandom_range(0, 40);
        if (r < 80) return $urandom_range(41, 130);
        if (r < 92) return $urandom_range(131, 300);
        return 32 * $urandom_range(1, 6) + $urandom_range(0, 2) - 1;
    endfunction

    // Offer one item and hold it until accepted
    task automatic offer_word(input logic [WORD_W-1:0] word, input logic [WORD_W-1:0] seed,
                              input logic [LEN_W-1:0] len);
        int gap;
        if (idling_on && $urandom_range(0, 4) == 0) begin
            push <= 1'b0;
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
        push           <= 1'b1;
        i_data_word    <= word;
        i_seed         <= seed;
        i_total_length <= len;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_word(word, seed, len);
        words_sent++;
    endtask

    // Send a whole message; seed and length on later items are noise
    task automatic send_message(input logic [WORD_W-1:0] seed, input logic [LEN_W-1:0] len,
                                input int fill);
        longint unsigned n_items, k;
        n_items = (len == 0) ? 1 : (({32'd0, len} + 64'd7) >> 3);
        offer_word(pick_word(fill), seed, len);
        for (k = 1; k < n_items; k++)
            offer_word(pick_word(fill), rand64(), $urandom);
    endtask

    // Drain every digest, let the engine settle, then set the round mode
    task automatic set_round_mode(input logic mode);
        push <= 1'b0;
        while (sb.expected_digests.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= mode;
        @(posedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        sb.round_mode = mode;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int   phase;
        int   target;
        logic mode;
        sb = new();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed messages in the reset mode: empty, tails, stripe edges
        send_message('0, 0, FILL_ONES);
        send_message('1, 0, FILL_RANDOM);
        send_message(rand64(), 1, FILL_ONES);
        send_message(rand64(), 7, FILL_ONES);
        send_message('1, 8, FILL_ZERO);
        send_message(rand64(), 31, FILL_ONES);
        send_message(rand64(), 32, FILL_RANDOM);
        send_message('0, 33, FILL_ONES);
        send_message('1, 40, FILL_RANDOM);

        // Random phases over alternating then random round modes
        for (phase = 0; phase < PHASE_COUNT; phase++) begin
            if (phase < 4) mode = phase[0] ? MODE_CROSS : MODE_CHAINED;
            else mode = 1'($urandom_range(0, 1));
            set_round_mode(mode);
            idling_on = (phase != PHASE_COUNT - 1);
            if (phase == 0) hold_off_req = 1'b1;
            if (phase == 2) send_message(rand64(), 1000, FILL_RANDOM);
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
                send_message(rand64(), pick_length(), FILL_RANDOM);
        end

        // Drain and finish
        push <= 1'b0;
        while (sb.expected_digests.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (sb.mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: pop with random stall bursts and one long hold-off
    // ------------------------------------------------------------------------
    initial begin
        int stall_left;
        stall_left = 0;
        wait (i_rst_n);
        forever begin
            if (hold_off_req) begin
                pop <= 1'b0;
                repeat (HOLD_OFF_LEN) @(posedge i_clk);
                hold_off_req = 1'b0;
            end
            if (stall_left > 0) begin
                pop <= 1'b0;
                stall_left--;
            end else if (idling_on && $urandom_range(0, 4) == 0) begin
                pop <= 1'b0;
                stall_left = $urandom_range(1, 6) - 1;
            end else begin
                pop <= 1'b1;
            end
            @(posedge i_clk);
            if (pop && !empty) sb.check_digest(o_digest);
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no item accepted for %0d cycles", $time, quiet_cycles);
            $display("status: fail");
            $finish;
        end
    end

endmodule
